// ===== rtl/core/spct_pkg.sv =====
`default_nettype none
package spct_pkg;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_QUERY  = 2'd1,
    CMD_AXIS   = 2'd2,
    CMD_UNUSED = 2'd3
  } cmd_t;

  localparam logic [1:0] REG_COUNT  = 2'd0;
  localparam logic [1:0] REG_AXIS_R = 2'd1;
  localparam logic [1:0] REG_AXIS_Z = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQRT_A,
    ST_SQRT_B,
    ST_DIFF,
    ST_READ,
    ST_SEG,
    ST_PROD,
    ST_TEST,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load_item;
    logic sqrt_start;
    logic sqrt_end;
    logic seg_step;
    logic prod_step;
    logic test_step;
    logic first_seg;
  } ctrl_t;

  typedef struct packed {
    logic sqrt_done;
    logic last_seg;
    logic hit;
    logic few;
  } stat_t;

endpackage
`default_nettype wire

// ===== rtl/core/segment_polyline_crossing_test.sv =====
`default_nettype none
// Channel  Handshake                      Payload
// in       valid / ready                  command .. end_z
// out      out_valid / out_ready          inside_res
// cfg      cfg_valid / cfg_ready          cfg_index, cfg_data
// Load or unused command: straight to the result. Query or axis command:
// two serial square roots on one root unit, then per segment a memory
// read, differences, products and test; for further segments the read
// overlaps the previous test. Reset clears the controller, root unit and
// config registers; vertex memory and datapath registers are undefined.
// The block takes one item at a time; a stalled result holds the block.
module segment_polyline_crossing_test
  import spct_pkg::*;
#(
  parameter int MAX_VERTICES = 256,
  parameter int COORD_BITS   = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         valid,
  output logic                              ready,
  input  wire logic [1:0]                   command,
  input  wire logic [7:0]                   vertex_index,
  input  wire logic signed [COORD_BITS-1:0] vertex_r,
  input  wire logic signed [COORD_BITS-1:0] vertex_z,
  input  wire logic signed [COORD_BITS-1:0] start_x,
  input  wire logic signed [COORD_BITS-1:0] start_y,
  input  wire logic signed [COORD_BITS-1:0] start_z,
  input  wire logic signed [COORD_BITS-1:0] end_x,
  input  wire logic signed [COORD_BITS-1:0] end_y,
  input  wire logic signed [COORD_BITS-1:0] end_z,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic                              inside_res,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [1:0]                   cfg_index,
  input  wire logic [COORD_BITS-1:0]        cfg_data
);

  logic [8:0]                   vertex_count;
  logic signed [COORD_BITS-1:0] axis_radius;
  logic signed [COORD_BITS-1:0] axis_height;
  ctrl_t                        ctrl;
  stat_t                        stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= '0;
      axis_radius  <= '0;
      axis_height  <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_COUNT:  vertex_count <= cfg_data[8:0];
        REG_AXIS_R: axis_radius  <= cfg_data;
        REG_AXIS_Z: axis_height  <= cfg_data;
        default: ;
      endcase
    end
  end

  spct_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .valid      (valid),
    .ready      (ready),
    .command    (command),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .inside_res (inside_res),
    .stat       (stat),
    .ctrl       (ctrl)
  );

  spct_datapath #(.MAX_VERTICES(MAX_VERTICES), .COORD_BITS(COORD_BITS)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .stat         (stat),
    .command      (command),
    .vertex_index (vertex_index),
    .vertex_r     (vertex_r),
    .vertex_z     (vertex_z),
    .start_x      (start_x),
    .start_y      (start_y),
    .start_z      (start_z),
    .end_x        (end_x),
    .end_y        (end_y),
    .end_z        (end_z),
    .vertex_count (vertex_count),
    .axis_radius  (axis_radius),
    .axis_height  (axis_height)
  );

endmodule
`default_nettype wire

// ===== rtl/core/spct_isqrt.sv =====
`default_nettype none
module spct_isqrt
  import spct_pkg::*;
#(
  parameter int COORD_BITS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [COORD_BITS-1:0] mag_a,
  input  wire logic [COORD_BITS-1:0] mag_b,
  output logic                       done,
  output logic [COORD_BITS-1:0]      root
);

  localparam int MW = 2 * COORD_BITS;
  localparam int SW = 2 * COORD_BITS + 2;
  localparam int CW = $clog2(COORD_BITS + 1);

  logic [SW-1:0]         rem;
  logic [SW-1:0]         src;
  logic [COORD_BITS-1:0] res;
  logic [CW-1:0]         cnt;
  logic                  busy;
  logic [SW-1:0]         rem_sh;
  logic [SW-1:0]         trial;

  assign rem_sh = {rem[SW-3:0], src[SW-1:SW-2]};
  assign trial  = SW'({res, 2'b01});
  assign root   = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        src  <= {2'b00, MW'(mag_a) * MW'(mag_a) + MW'(mag_b) * MW'(mag_b)};
        rem  <= '0;
        res  <= '0;
        cnt  <= CW'(COORD_BITS + 1);
      end else if (busy) begin
        src <= {src[SW-3:0], 2'b00};
        if (rem_sh >= trial) begin
          rem <= rem_sh - trial;
          res <= {res[COORD_BITS-2:0], 1'b1};
        end else begin
          rem <= rem_sh;
          res <= {res[COORD_BITS-2:0], 1'b0};
        end
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/spct_datapath.sv =====
`default_nettype none
module spct_datapath
  import spct_pkg::*;
#(
  parameter int MAX_VERTICES = 256,
  parameter int COORD_BITS   = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire ctrl_t                        ctrl,
  output stat_t                             stat,
  input  wire logic [1:0]                   command,
  input  wire logic [7:0]                   vertex_index,
  input  wire logic signed [COORD_BITS-1:0] vertex_r,
  input  wire logic signed [COORD_BITS-1:0] vertex_z,
  input  wire logic signed [COORD_BITS-1:0] start_x,
  input  wire logic signed [COORD_BITS-1:0] start_y,
  input  wire logic signed [COORD_BITS-1:0] start_z,
  input  wire logic signed [COORD_BITS-1:0] end_x,
  input  wire logic signed [COORD_BITS-1:0] end_y,
  input  wire logic signed [COORD_BITS-1:0] end_z,
  input  wire logic [8:0]                   vertex_count,
  input  wire logic signed [COORD_BITS-1:0] axis_radius,
  input  wire logic signed [COORD_BITS-1:0] axis_height
);

  localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int NW = $clog2(MAX_VERTICES + 1);
  localparam int CB = COORD_BITS;
  localparam int DW = CB + 2;
  localparam int PW = 2 * DW;
  localparam int WW = PW + 1;

  logic signed [CB-1:0] mem_r [MAX_VERTICES];
  logic signed [CB-1:0] mem_z [MAX_VERTICES];
  logic signed [CB-1:0] rd_r;
  logic signed [CB-1:0] rd_z;
  logic [AW-1:0]        rd_addr;
  logic [NW-1:0]        seg;
  logic [NW-1:0]        n_used;

  logic signed [CB-1:0] ex_r, ex_z;
  logic signed [CB-1:0] sxx, syy, szz;
  logic signed [CB:0]   r0;
  logic signed [CB:0]   z0;
  logic signed [DW-1:0] dr, dz;
  logic signed [CB-1:0] prev_r, prev_z;
  logic signed [DW-1:0] sr, sz, ox, oz;
  logic                 coinc;
  logic signed [PW-1:0] p_srdz, p_drsz, p_oxdz, p_ozdr, p_oxsz, p_ozsr;
  logic signed [WW-1:0] det, ns, nt;
  logic                 hit;

  logic                 sq_start, sq_done;
  logic [CB-1:0]        sq_root;
  logic [CB-1:0]        mag_x, mag_y;

  logic [NW:0]          cnt_cap;

  assign cnt_cap = (NW+1)'(vertex_count) > (NW+1)'(MAX_VERTICES) ?
                   (NW+1)'(MAX_VERTICES) : (NW+1)'(vertex_count);

  always_ff @(posedge clk) begin
    if (ctrl.load_item && command == CMD_LOAD &&
        32'(vertex_index) < 32'(MAX_VERTICES)) begin
      mem_r[AW'(vertex_index)] <= vertex_r;
      mem_z[AW'(vertex_index)] <= vertex_z;
    end
    rd_r <= mem_r[rd_addr];
    rd_z <= mem_z[rd_addr];
  end

  assign rd_addr = ctrl.first_seg ? '0 :
                   ctrl.seg_step  ? AW'(seg + NW'(1)) : seg[AW-1:0];

  always_comb begin
    if (ctrl.sqrt_start) begin
      mag_x = sxx[CB-1] ? CB'(-sxx) : CB'(sxx);
      mag_y = syy[CB-1] ? CB'(-syy) : CB'(syy);
    end else begin
      mag_x = ex_r[CB-1] ? CB'(-ex_r) : CB'(ex_r);
      mag_y = ex_z[CB-1] ? CB'(-ex_z) : CB'(ex_z);
    end
  end

  assign sq_start = ctrl.sqrt_start || ctrl.sqrt_end;

  spct_isqrt #(.COORD_BITS(CB)) u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .mag_a (mag_x),
    .mag_b (mag_y),
    .done  (sq_done),
    .root  (sq_root)
  );

  always_ff @(posedge clk) begin
    if (ctrl.load_item) begin
      if (command == CMD_AXIS) begin
        sxx <= axis_radius;
        syy <= '0;
        szz <= axis_height;
      end else begin
        sxx <= start_x;
        syy <= start_y;
        szz <= start_z;
      end
      ex_r   <= end_x;
      ex_z   <= end_y;
      dz     <= DW'(end_z) - DW'(command == CMD_AXIS ? axis_height : start_z);
      n_used <= NW'(cnt_cap);
    end
    if (ctrl.sqrt_end) begin
      r0 <= {1'b0, sq_root};
      z0 <= (CB+1)'(szz);
    end
    if (ctrl.seg_step) begin
      dr <= DW'({1'b0, sq_root}) - DW'(r0);
    end
    if (ctrl.first_seg) begin
      seg <= '0;
    end else if (ctrl.seg_step) begin
      seg    <= seg + NW'(1);
      prev_r <= rd_r;
      prev_z <= rd_z;
    end
    if (ctrl.prod_step) begin
      sr    <= DW'(rd_r) - DW'(prev_r);
      sz    <= DW'(rd_z) - DW'(prev_z);
      ox    <= DW'(r0) - DW'(prev_r);
      oz    <= DW'(z0) - DW'(prev_z);
      coinc <= (DW'(r0) == DW'(prev_r)) && (DW'(z0) == DW'(prev_z));
    end
    if (ctrl.test_step) begin
      p_srdz <= sr * dz;
      p_drsz <= dr * sz;
      p_oxdz <= ox * dz;
      p_ozdr <= oz * dr;
      p_oxsz <= ox * sz;
      p_ozsr <= oz * sr;
    end
  end

  function automatic logic in_unit(input logic signed [WW-1:0] num,
                                   input logic signed [WW-1:0] d);
    logic signed [WW:0] diff;
    logic neg_n, zer_n, neg_c, zer_c;
    diff  = (WW+1)'(num) - (WW+1)'(d);
    neg_n = num[WW-1];
    zer_n = (num == '0);
    neg_c = diff[WW];
    zer_c = (diff == '0);
    if (!d[WW-1]) in_unit = !neg_n && (neg_c || zer_c);
    else          in_unit = (neg_n || zer_n) && !neg_c;
  endfunction

  assign det = WW'(p_srdz) - WW'(p_drsz);
  assign ns  = WW'(p_oxdz) - WW'(p_ozdr);
  assign nt  = WW'(p_oxsz) - WW'(p_ozsr);
  assign hit = coinc || (det != '0 && in_unit(ns, det) && in_unit(nt, det));

  assign stat.sqrt_done = sq_done;
  assign stat.last_seg  = ((seg + NW'(1)) >= n_used);
  assign stat.hit       = hit;
  assign stat.few       = (n_used < NW'(2));

endmodule
`default_nettype wire

// ===== rtl/core/spct_ctrl.sv =====
`default_nettype none
module spct_ctrl
  import spct_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       valid,
  output logic            ready,
  input  wire logic [1:0] command,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            inside_res,
  input  wire stat_t      stat,
  output ctrl_t           ctrl
);

  state_t state, state_next;
  logic   res, res_next;
  logic   item_acc;

  assign item_acc   = valid && ready;
  assign ready      = (state == ST_IDLE);
  assign out_valid  = (state == ST_OUT);
  assign inside_res = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      res   <= 1'b1;
    end else begin
      state <= state_next;
      res   <= res_next;
    end
  end

  always_comb begin
    state_next = state;
    res_next   = res;
    ctrl       = '0;
    case (state)
      ST_IDLE: begin
        ctrl.load_item = item_acc;
        if (item_acc) begin
          res_next = 1'b1;
          if (command == CMD_QUERY || command == CMD_AXIS) state_next = ST_SQRT_A;
          else state_next = ST_OUT;
        end
      end
      ST_SQRT_A: begin
        ctrl.sqrt_start = 1'b1;
        state_next      = ST_SQRT_B;
      end
      ST_SQRT_B: begin
        if (stat.sqrt_done) begin
          ctrl.sqrt_end = 1'b1;
          state_next    = ST_DIFF;
        end
      end
      ST_DIFF: begin
        if (stat.sqrt_done) begin
          ctrl.seg_step  = 1'b1;
          ctrl.first_seg = 1'b1;
          state_next     = stat.few ? ST_OUT : ST_READ;
        end
      end
      ST_READ: begin
        ctrl.seg_step = 1'b1;
        state_next    = ST_SEG;
      end
      ST_SEG: begin
        ctrl.prod_step = 1'b1;
        state_next     = ST_PROD;
      end
      ST_PROD: begin
        ctrl.test_step = 1'b1;
        state_next     = ST_TEST;
      end
      ST_TEST: begin
        if (stat.hit) begin
          res_next   = 1'b0;
          state_next = ST_OUT;
        end else if (stat.last_seg) begin
          state_next = ST_OUT;
        end else begin
          ctrl.seg_step = 1'b1;
          state_next    = ST_SEG;
        end
      end
      ST_OUT: begin
        if (out_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  a_ready_only_idle: assert property (@(posedge clk) disable iff (rst)
    ready |-> !out_valid) else $error("ready while result pending");
  a_out_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(inside_res))
    else $error("result dropped");
  a_load_direct: assert property (@(posedge clk) disable iff (rst)
    item_acc && command == CMD_LOAD |=> out_valid && inside_res)
    else $error("load result wrong");

endmodule
`default_nettype wire
